### hw/rtl/pfe_pkg.sv
`default_nettype none

package pfe_pkg;

  localparam int unsigned IDX_W       = 4;
  localparam int unsigned CH_W        = 12;
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned PROD_W      = CH_W + RECIP_W;
  localparam int unsigned Q_W         = PROD_W - RECIP_SHIFT;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // floor(d * 2048 / 1365) == (d * RECIP) >> RECIP_SHIFT for d < 4096
  localparam logic [RECIP_W-1:0] RECIP    = 25'd25171970;
  localparam logic [CH_W-1:0]    PPM_LOW  = 12'd817;
  localparam logic [10:0]        CODE_MIN = 11'd1;
  localparam logic [10:0]        CODE_MAX = 11'd2046;

  localparam logic [IDX_W-1:0] IDX_OPEN  = 4'd0;
  localparam logic [IDX_W-1:0] IDX_CLOSE = 4'd15;

  localparam logic [7:0] RX_NUM_RESET = 8'd16;
  localparam logic       REG_RX_NUM   = 1'b0;

  localparam logic [15:0] CRC_NIBBLE [16] = '{
    16'h0000, 16'h1189, 16'h2312, 16'h329B, 16'h4624, 16'h57AD, 16'h6536, 16'h74BF,
    16'h8C48, 16'h9DC1, 16'hAF5A, 16'hBED3, 16'hCA6C, 16'hDBE5, 16'hE97E, 16'hF8F7
  };

  typedef struct packed {
    logic       open;
    logic       pair;
    logic       close;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } cmd_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_end;
    logic       frame_end;
  } out_t;

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] d);
    logic [7:0]  v;
    logic [15:0] t;
    v = crc[15:8] ^ d;
    t = CRC_NIBBLE[v[3:0]] ^ 16'(16'h1081 * {12'd0, v[7:4]});
    crc_next = {crc[7:0], 8'd0} ^ t;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/pxx_frame_encoder_core.sv
`default_nettype none

// Frame encoder core: one channel pulse width in, pulse-coded line bytes out.
// Input queue side: in_channel_index/in_channel_value are taken when push is
// high and full is low. Result queue side: the oldest line byte sits on the
// out_ ports while empty is low and leaves when pop is high.
// out_run_end marks the last byte an input transfer produced, out_frame_end
// the last byte of the frame-closing transfer.
// The front stage steps through capture, reciprocal multiply, and clamp and
// classify, and takes no new item until it hands the command to a
// CMD_DEPTH-entry queue. The back sequencer emits one line bit per cycle
// while the result queue has room, and also steps through each frame slot and
// the fetch and wrap-up; it sets the sustained rate. Each byte waits for the
// next one or the item's end before it enters the result queue.
// When pop stays low the OUT_DEPTH-entry result queue fills and the
// sequencer halts in place; the command queue and front then fill and full rises.
// Reset (synchronous, rst_n low) empties both queues, clears the CRC, the
// bit packer and the half select, and sets receiver_number to 16.
// Configuration: APB write to byte addresses 0 to 3 (paddr[2] low) sets receiver_number.

module pxx_frame_encoder_core #(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [pfe_pkg::IDX_W-1:0]      in_channel_index,
  input  wire logic [pfe_pkg::CH_W-1:0]       in_channel_value,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [7:0]                          out_line_byte,
  output logic                                out_run_end,
  output logic                                out_frame_end,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pfe_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [pfe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfe_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  logic [7:0]    rx_num_r;
  logic          reg_hit;

  pfe_pkg::cmd_t front_cmd, back_cmd;
  logic          front_valid, cmd_full, cmd_empty, cmd_pop;
  pfe_pkg::out_t back_item, out_head;
  logic          out_push, out_full;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[pfe_pkg::CFG_ADDR_W-1:2] == pfe_pkg::REG_RX_NUM);
  assign prdata  = reg_hit ? pfe_pkg::CFG_DATA_W'(rx_num_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_num_r <= pfe_pkg::RX_NUM_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      rx_num_r <= pwdata[7:0];
    end
  end

  pfe_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_channel_index (in_channel_index),
    .in_channel_value (in_channel_value),
    .cmd_valid        (front_valid),
    .cmd_ready        (!cmd_full),
    .cmd              (front_cmd)
  );

  pfe_fifo #(
    .WIDTH ($bits(pfe_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_valid),
    .wr_data (front_cmd),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (back_cmd),
    .empty   (cmd_empty)
  );

  pfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_num    (rx_num_r),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (back_cmd),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (back_item)
  );

  pfe_fifo #(
    .WIDTH ($bits(pfe_pkg::out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_push),
    .wr_data (back_item),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_head),
    .empty   (empty)
  );

  assign out_line_byte = out_head.line_byte;
  assign out_run_end   = out_head.run_end;
  assign out_frame_end = out_head.frame_end;

endmodule

`default_nettype wire

### hw/rtl/pfe_fifo.sv
`default_nettype none

module pfe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pfe_front.sv
`default_nettype none

module pfe_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [pfe_pkg::IDX_W-1:0] in_channel_index,
  input  wire logic [pfe_pkg::CH_W-1:0]  in_channel_value,
  output logic                           cmd_valid,
  input  wire logic                      cmd_ready,
  output pfe_pkg::cmd_t                  cmd
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                         state_r, state_nxt;
  logic [pfe_pkg::IDX_W-1:0]       idx_r;
  logic [pfe_pkg::CH_W-1:0]        val_r;
  logic                            below_r;
  logic [pfe_pkg::PROD_W-1:0]      prod_r;
  logic                            upper_r, upper_nxt;
  logic [pfe_pkg::CH_W-1:0]        held_r, held_nxt;
  logic [pfe_pkg::CH_W-1:0]        delta;
  logic [pfe_pkg::Q_W-1:0]         q;
  logic [10:0]                     code;
  logic [pfe_pkg::CH_W-1:0]        chan;
  logic                            in_half;

  assign full  = (state_r != F_IDLE);
  assign delta = val_r - pfe_pkg::PPM_LOW;
  assign q     = prod_r[pfe_pkg::RECIP_SHIFT +: pfe_pkg::Q_W];

  always_comb begin
    if (below_r || (q == '0)) begin
      code = pfe_pkg::CODE_MIN;
    end else if (q > pfe_pkg::Q_W'(pfe_pkg::CODE_MAX)) begin
      code = pfe_pkg::CODE_MAX;
    end else begin
      code = q[10:0];
    end
  end

  // upper half adds 2048: the half bit lands on the top bit
  assign chan    = {upper_r, code};
  assign in_half = (idx_r[pfe_pkg::IDX_W-1] == upper_r);

  always_comb begin
    cmd.open  = (idx_r == pfe_pkg::IDX_OPEN);
    cmd.pair  = in_half && idx_r[0];
    cmd.close = (idx_r == pfe_pkg::IDX_CLOSE);
    cmd.b0    = held_r[7:0];
    cmd.b1    = {chan[3:0], held_r[11:8]};
    cmd.b2    = chan[11:4];
  end

  assign cmd_valid = (state_r == F_PUSH);

  always_comb begin
    state_nxt = state_r;
    upper_nxt = upper_r;
    held_nxt  = held_r;
    unique case (state_r)
      F_IDLE: begin
        if (push) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (cmd_ready) begin
          state_nxt = F_IDLE;
          if (in_half && !idx_r[0]) begin
            held_nxt = chan;
          end
          if (idx_r == pfe_pkg::IDX_CLOSE) begin
            upper_nxt = !upper_r;
          end
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      upper_r <= 1'b0;
      held_r  <= '0;
    end else begin
      state_r <= state_nxt;
      upper_r <= upper_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == F_IDLE) && push) begin
      idx_r <= in_channel_index;
      val_r <= in_channel_value;
    end
    if (state_r == F_MUL) begin
      below_r <= (val_r < pfe_pkg::PPM_LOW);
      prod_r  <= pfe_pkg::PROD_W'(delta) * pfe_pkg::PROD_W'(pfe_pkg::RECIP);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pfe_back.sv
`default_nettype none

module pfe_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    rx_num,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  input  wire pfe_pkg::cmd_t cmd,
  input  wire logic          out_full,
  output logic               out_push,
  output pfe_pkg::out_t      out_item
);

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_LOAD  = 7'b0000010,
    B_PRE   = 7'b0000100,
    B_SYNC  = 7'b0001000,
    B_DATA  = 7'b0010000,
    B_FLUSH = 7'b0100000,
    B_DONE  = 7'b1000000
  } bstate_t;

  typedef enum logic [2:0] {
    K_PRE   = 3'd0,
    K_SYNC  = 3'd1,
    K_DATA  = 3'd2,
    K_FLUSH = 3'd3,
    K_DONE  = 3'd4
  } slot_kind_t;

  localparam logic [3:0] SLOT_PRE    = 4'd0;
  localparam logic [3:0] SLOT_SYNC_O = 4'd1;
  localparam logic [3:0] SLOT_RX     = 4'd2;
  localparam logic [3:0] SLOT_FLAG0  = 4'd3;
  localparam logic [3:0] SLOT_FLAG1  = 4'd4;
  localparam logic [3:0] SLOT_CH0    = 4'd5;
  localparam logic [3:0] SLOT_CH1    = 4'd6;
  localparam logic [3:0] SLOT_CH2    = 4'd7;
  localparam logic [3:0] SLOT_PAD    = 4'd8;
  localparam logic [3:0] SLOT_CRC_HI = 4'd9;
  localparam logic [3:0] SLOT_CRC_LO = 4'd10;
  localparam logic [3:0] SLOT_SYNC_C = 4'd11;
  localparam logic [3:0] SLOT_FLUSH  = 4'd12;
  localparam logic [3:0] SLOT_DONE   = 4'd13;

  bstate_t       state_r, state_nxt;
  logic [3:0]    seq_r, seq_nxt;
  pfe_pkg::cmd_t cmd_r, cmd_nxt;
  logic [1:0]    part_pos_r, part_pos_nxt;
  logic          part_one_r, part_one_nxt;
  logic [2:0]    part_idx_r, part_idx_nxt;
  logic          stuff_r, stuff_nxt;
  logic [7:0]    dshift_r, dshift_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    crc_lo_r, crc_lo_nxt;
  logic [2:0]    ones_r, ones_nxt;
  logic [7:0]    pack_shift_r, pack_shift_nxt;
  logic [2:0]    pack_cnt_r, pack_cnt_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic [7:0]    pend_byte_r, pend_byte_nxt;

  logic          slot_en;
  logic [7:0]    slot_byte;
  slot_kind_t    slot_kind;
  logic          adv, part_last, emit, emit_bit, next_bit;

  always_comb begin
    slot_en   = 1'b0;
    slot_byte = 8'd0;
    slot_kind = K_DATA;
    unique case (seq_r) inside
      SLOT_PRE: begin
        slot_en   = cmd_r.open;
        slot_kind = K_PRE;
      end
      SLOT_SYNC_O: begin
        slot_en   = cmd_r.open;
        slot_kind = K_SYNC;
      end
      SLOT_RX: begin
        slot_en   = cmd_r.open;
        slot_byte = rx_num;
      end
      SLOT_FLAG0, SLOT_FLAG1: begin
        slot_en = cmd_r.open;
      end
      SLOT_CH0: begin
        slot_en   = cmd_r.pair;
        slot_byte = cmd_r.b0;
      end
      SLOT_CH1: begin
        slot_en   = cmd_r.pair;
        slot_byte = cmd_r.b1;
      end
      SLOT_CH2: begin
        slot_en   = cmd_r.pair;
        slot_byte = cmd_r.b2;
      end
      SLOT_PAD: begin
        slot_en = cmd_r.close;
      end
      SLOT_CRC_HI: begin
        slot_en   = cmd_r.close;
        slot_byte = crc_r[15:8];
      end
      SLOT_CRC_LO: begin
        slot_en   = cmd_r.close;
        slot_byte = crc_lo_r;
      end
      SLOT_SYNC_C: begin
        slot_en   = cmd_r.close;
        slot_kind = K_SYNC;
      end
      SLOT_FLUSH: begin
        slot_en   = cmd_r.close;
        slot_kind = K_FLUSH;
      end
      SLOT_DONE: begin
        slot_en   = 1'b1;
        slot_kind = K_DONE;
      end
      default: begin
        slot_en   = 1'b1;
        slot_kind = K_DONE;
      end
    endcase
  end

  assign adv       = !out_full;
  assign part_last = (part_pos_r == (part_one_r ? 2'd2 : 2'd1));

  always_comb begin
    state_nxt      = state_r;
    seq_nxt        = seq_r;
    cmd_nxt        = cmd_r;
    part_pos_nxt   = part_pos_r;
    part_one_nxt   = part_one_r;
    part_idx_nxt   = part_idx_r;
    stuff_nxt      = stuff_r;
    dshift_nxt     = dshift_r;
    crc_nxt        = crc_r;
    crc_lo_nxt     = crc_lo_r;
    ones_nxt       = ones_r;
    pack_shift_nxt = pack_shift_r;
    pack_cnt_nxt   = pack_cnt_r;
    pend_vld_nxt   = pend_vld_r;
    pend_byte_nxt  = pend_byte_r;
    cmd_pop        = 1'b0;
    out_push       = 1'b0;
    out_item       = '0;
    emit           = 1'b0;
    emit_bit       = 1'b0;
    next_bit       = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          cmd_nxt   = cmd;
          cmd_pop   = 1'b1;
          seq_nxt   = SLOT_PRE;
          state_nxt = B_LOAD;
        end
      end

      B_LOAD: begin
        if (!slot_en) begin
          seq_nxt = seq_r + 4'd1;
        end else begin
          part_pos_nxt = 2'd0;
          part_idx_nxt = 3'd0;
          part_one_nxt = 1'b0;
          unique case (slot_kind)
            K_PRE: begin
              crc_nxt   = '0;
              ones_nxt  = '0;
              state_nxt = B_PRE;
            end
            K_SYNC: begin
              state_nxt = B_SYNC;
            end
            K_DATA: begin
              crc_nxt      = pfe_pkg::crc_next(crc_r, slot_byte);
              dshift_nxt   = slot_byte;
              part_one_nxt = slot_byte[7];
              stuff_nxt    = 1'b0;
              state_nxt    = B_DATA;
              if (seq_r == SLOT_CRC_HI) begin
                crc_lo_nxt = crc_r[7:0];
              end
            end
            K_FLUSH: begin
              state_nxt = B_FLUSH;
            end
            K_DONE: begin
              state_nxt = B_DONE;
            end
            default: begin
              state_nxt = B_DONE;
            end
          endcase
        end
      end

      B_PRE: begin
        if (adv) begin
          emit     = 1'b1;
          emit_bit = part_last;
          if (!part_last) begin
            part_pos_nxt = part_pos_r + 2'd1;
          end else begin
            part_pos_nxt = 2'd0;
            if (part_idx_r == 3'd3) begin
              seq_nxt   = seq_r + 4'd1;
              state_nxt = B_LOAD;
            end else begin
              part_idx_nxt = part_idx_r + 3'd1;
            end
          end
        end
      end

      B_SYNC: begin
        if (adv) begin
          emit     = 1'b1;
          emit_bit = part_last;
          if (!part_last) begin
            part_pos_nxt = part_pos_r + 2'd1;
          end else begin
            part_pos_nxt = 2'd0;
            if (part_idx_r == 3'd7) begin
              seq_nxt   = seq_r + 4'd1;
              state_nxt = B_LOAD;
            end else begin
              part_idx_nxt = part_idx_r + 3'd1;
              part_one_nxt = (part_idx_r != 3'd6);
            end
          end
        end
      end

      B_DATA: begin
        if (adv) begin
          emit     = 1'b1;
          emit_bit = part_last;
          if (!part_last) begin
            part_pos_nxt = part_pos_r + 2'd1;
          end else begin
            part_pos_nxt = 2'd0;
            if (stuff_r) begin
              stuff_nxt = 1'b0;
              next_bit  = 1'b1;
            end else if (part_one_r && (ones_r == 3'd4)) begin
              // fifth one in a row: a stuffed zero follows
              ones_nxt     = 3'd0;
              stuff_nxt    = 1'b1;
              part_one_nxt = 1'b0;
            end else begin
              ones_nxt = part_one_r ? ones_r + 3'd1 : 3'd0;
              next_bit = 1'b1;
            end
            if (next_bit) begin
              if (part_idx_r == 3'd7) begin
                seq_nxt   = seq_r + 4'd1;
                state_nxt = B_LOAD;
              end else begin
                part_idx_nxt = part_idx_r + 3'd1;
                dshift_nxt   = {dshift_r[6:0], 1'b0};
                part_one_nxt = dshift_r[6];
              end
            end
          end
        end
      end

      B_FLUSH: begin
        if (pack_cnt_r == 3'd0) begin
          seq_nxt   = seq_r + 4'd1;
          state_nxt = B_LOAD;
        end else if (adv) begin
          emit     = 1'b1;
          emit_bit = 1'b1;
        end
      end

      B_DONE: begin
        if (adv) begin
          if (pend_vld_r) begin
            out_push           = 1'b1;
            out_item.line_byte = pend_byte_r;
            out_item.run_end   = 1'b1;
            out_item.frame_end = cmd_r.close;
            pend_vld_nxt       = 1'b0;
          end
          state_nxt = B_IDLE;
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    // the newest finished byte waits until the next one or the end of the item
    if (emit) begin
      pack_shift_nxt = {emit_bit, pack_shift_r[7:1]};
      pack_cnt_nxt   = pack_cnt_r + 3'd1;
      if (pack_cnt_r == 3'd7) begin
        if (pend_vld_r) begin
          out_push           = 1'b1;
          out_item.line_byte = pend_byte_r;
        end
        pend_byte_nxt = {emit_bit, pack_shift_r[7:1]};
        pend_vld_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      crc_r        <= '0;
      ones_r       <= '0;
      pack_shift_r <= '0;
      pack_cnt_r   <= '0;
      pend_vld_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      crc_r        <= crc_nxt;
      ones_r       <= ones_nxt;
      pack_shift_r <= pack_shift_nxt;
      pack_cnt_r   <= pack_cnt_nxt;
      pend_vld_r   <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r       <= seq_nxt;
    cmd_r       <= cmd_nxt;
    part_pos_r  <= part_pos_nxt;
    part_one_r  <= part_one_nxt;
    part_idx_r  <= part_idx_nxt;
    stuff_r     <= stuff_nxt;
    dshift_r    <= dshift_nxt;
    crc_lo_r    <= crc_lo_nxt;
    pend_byte_r <= pend_byte_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/pfe_checker.sv
`default_nettype none

module pfe_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       push,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_line_byte,
  input wire logic       out_run_end,
  input wire logic       out_frame_end
);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_end) |-> out_run_end)
    else $error("frame end without run end");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> full)
    else $error("front ready again right after an input transfer");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_line_byte) && $stable(out_run_end)
                          && $stable(out_frame_end)))
    else $error("stalled result changed");

endmodule

bind pxx_frame_encoder_core pfe_checker u_pfe_checker (.*);

`default_nettype wire
